>>> src/smo_gus_pkg.sv
// Shared types and constants for the SMO gradient update and selection block.
// No dependencies; the design files refer to it by scoped name, the bench files import it.
`default_nettype none

package smo_gus_pkg;

  localparam int IDX_W    = 16;
  localparam int VAL_W    = 32;
  localparam int KER_W    = 17;
  localparam int ALPHA_W  = 31;
  localparam int COST_W   = 31;
  localparam int EPS_W    = 16;
  localparam int TOL_W    = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 5;
  localparam int REG_SEL_W = 3;

  // Product of a signed coefficient and a zero-extended kernel.
  localparam int PROD_W = VAL_W + KER_W + 1;
  // Exact Q.32 sum of the shifted gradient and the two products.
  localparam int ACC_W  = PROD_W + 2;

  localparam logic [COST_W-1:0]  COST_RESET = COST_W'(65536);
  localparam logic [EPS_W-1:0]   EPS_RESET  = EPS_W'(1);
  localparam logic [TOL_W-1:0]   TOL_RESET  = TOL_W'(66);

  typedef enum logic [REG_SEL_W-1:0] {
    REG_COEF_HIGH = 3'd0,
    REG_COEF_LOW  = 3'd1,
    REG_COST      = 3'd2,
    REG_EPSILON   = 3'd3,
    REG_TOLERANCE = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> src/smo_gus_point_if.sv
// Input channel carrying one training point per transaction.
// Depends on smo_gus_pkg for field widths.
`default_nettype none

interface smo_gus_point_if;
  logic                                 valid;
  logic                                 ready;
  logic [smo_gus_pkg::IDX_W-1:0]        point_index;
  logic signed [smo_gus_pkg::VAL_W-1:0] f_old;
  logic [smo_gus_pkg::KER_W-1:0]        kernel_high;
  logic [smo_gus_pkg::KER_W-1:0]        kernel_low;
  logic                                 label_positive;
  logic [smo_gus_pkg::ALPHA_W-1:0]      alpha_value;
  logic                                 last_point;

  modport source (
    output valid, point_index, f_old, kernel_high, kernel_low, label_positive,
           alpha_value, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_index, f_old, kernel_high, kernel_low, label_positive,
           alpha_value, last_point,
    output ready
  );
endinterface

`default_nettype wire

>>> src/smo_gus_result_if.sv
// Output channel carrying one updated gradient and the pass summary per transaction.
// Depends on smo_gus_pkg for field widths.
`default_nettype none

interface smo_gus_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [smo_gus_pkg::VAL_W-1:0] f_new;
  logic [smo_gus_pkg::IDX_W-1:0]        high_index;
  logic signed [smo_gus_pkg::VAL_W-1:0] high_value;
  logic                                 high_found;
  logic [smo_gus_pkg::IDX_W-1:0]        low_index;
  logic signed [smo_gus_pkg::VAL_W-1:0] low_value;
  logic                                 low_found;
  logic                                 converged;
  logic                                 pass_end;

  modport source (
    output valid, f_new, high_index, high_value, high_found, low_index, low_value,
           low_found, converged, pass_end,
    input  ready
  );
  modport sink (
    input  valid, f_new, high_index, high_value, high_found, low_index, low_value,
           low_found, converged, pass_end,
    output ready
  );
endinterface

`default_nettype wire

>>> src/smo_gradient_update_select_top.sv
// Top level of the SMO gradient update and working-set selection block.
// Depends on smo_gus_pkg, smo_gus_point_if and smo_gus_result_if.
//
// Usage: training points stream in on the points channel, one transaction per
// point, in pass order. Each point yields exactly one transaction on the results
// channel holding its updated gradient f_new, rounded and saturated to Q15.16.
// The transaction of the point flagged last_point also carries the pass summary:
// the minimum-gradient point of the high set, the maximum-gradient point of the
// low set, their found flags and the convergence verdict. After it the running
// minimum and maximum are cleared for the next pass.
// The coefficients and thresholds are to be written over the APB port between
// passes; the block itself does not enforce this. A point passes through the
// input, product, gradient and result registers before it is presented as a
// result. One point can be accepted every cycle while the receiver keeps ready
// high; the sustained rate is one point per cycle, set by the compare-and-update
// loop on the running minimum and maximum in the last stage.
// Stalls: every stage holds its own valid bit, so bubbles are squeezed out and
// points keep being accepted until all four registers are full while the
// receiver holds ready low.
// Reset (rst, synchronous, active high) empties the pipeline, clears the
// running minimum and maximum, and restores the register defaults.
`default_nettype none

module smo_gradient_update_select_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  smo_gus_point_if.sink                           points,
  smo_gus_result_if.source                        results,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [smo_gus_pkg::APB_AW-1:0]     paddr,
  input  wire logic [smo_gus_pkg::APB_DW-1:0]     pwdata,
  output logic      [smo_gus_pkg::APB_DW-1:0]     prdata,
  output logic                                    pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [smo_gus_pkg::VAL_W-1:0] coef_high;
  logic signed [smo_gus_pkg::VAL_W-1:0] coef_low;
  logic [smo_gus_pkg::COST_W-1:0]       cost;
  logic [smo_gus_pkg::EPS_W-1:0]        epsilon;
  logic [smo_gus_pkg::TOL_W-1:0]        tolerance;

  smo_gus_pkg::cfg_reg_t reg_sel;
  logic                  cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = smo_gus_pkg::cfg_reg_t'(paddr[smo_gus_pkg::APB_AW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_high <= '0;
      coef_low  <= '0;
      cost      <= smo_gus_pkg::COST_RESET;
      epsilon   <= smo_gus_pkg::EPS_RESET;
      tolerance <= smo_gus_pkg::TOL_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        smo_gus_pkg::REG_COEF_HIGH: coef_high <= pwdata;
        smo_gus_pkg::REG_COEF_LOW:  coef_low  <= pwdata;
        smo_gus_pkg::REG_COST:      cost      <= pwdata[smo_gus_pkg::COST_W-1:0];
        smo_gus_pkg::REG_EPSILON:   epsilon   <= pwdata[smo_gus_pkg::EPS_W-1:0];
        smo_gus_pkg::REG_TOLERANCE: tolerance <= pwdata[smo_gus_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      smo_gus_pkg::REG_COEF_HIGH: prdata = coef_high;
      smo_gus_pkg::REG_COEF_LOW:  prdata = coef_low;
      smo_gus_pkg::REG_COST:      prdata = smo_gus_pkg::APB_DW'(cost);
      smo_gus_pkg::REG_EPSILON:   prdata = smo_gus_pkg::APB_DW'(epsilon);
      smo_gus_pkg::REG_TOLERANCE: prdata = smo_gus_pkg::APB_DW'(tolerance);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or when the stage
  // after it loads, so a stall only backs up as far as it must.
  // ---------------------------------------------------------------------------
  logic s0_valid, s1_valid, s2_valid, out_valid;
  logic s0_load, s1_load, s2_load, out_load;

  assign out_load = !out_valid || results.ready;
  assign s2_load  = !s2_valid || out_load;
  assign s1_load  = !s1_valid || s2_load;
  assign s0_load  = !s0_valid || s1_load;
  assign points.ready = s0_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s0_load)  s0_valid  <= points.valid;
      if (s1_load)  s1_valid  <= s0_valid;
      if (s2_load)  s2_valid  <= s1_valid;
      if (out_load) out_valid <= s2_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register.
  // ---------------------------------------------------------------------------
  logic [smo_gus_pkg::IDX_W-1:0]        s0_index;
  logic signed [smo_gus_pkg::VAL_W-1:0] s0_f_old;
  logic [smo_gus_pkg::KER_W-1:0]        s0_kernel_high;
  logic [smo_gus_pkg::KER_W-1:0]        s0_kernel_low;
  logic                                 s0_positive;
  logic [smo_gus_pkg::ALPHA_W-1:0]      s0_alpha;
  logic                                 s0_last;

  always_ff @(posedge clk) begin
    if (s0_load) begin
      s0_index       <= points.point_index;
      s0_f_old       <= points.f_old;
      s0_kernel_high <= points.kernel_high;
      s0_kernel_low  <= points.kernel_low;
      s0_positive    <= points.label_positive;
      s0_alpha       <= points.alpha_value;
      s0_last        <= points.last_point;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the two kernel products and the set membership of the point.
  // A point is in the high set if positive with alpha below cost minus epsilon,
  // or negative with alpha above epsilon; the low set is the mirror image.
  // Cost minus epsilon is kept signed so that a cost below epsilon excludes
  // every alpha.
  // ---------------------------------------------------------------------------
  logic signed [smo_gus_pkg::COST_W+1:0] c_eps;
  logic signed [smo_gus_pkg::COST_W+1:0] alpha_ext;
  logic                                  alpha_below;
  logic                                  alpha_above;

  assign c_eps       = $signed({2'b00, cost}) -
                       $signed({(smo_gus_pkg::COST_W + 2 - smo_gus_pkg::EPS_W)'(0), epsilon});
  assign alpha_ext   = $signed({2'b00, s0_alpha});
  assign alpha_below = alpha_ext < c_eps;
  assign alpha_above = s0_alpha > smo_gus_pkg::ALPHA_W'(epsilon);

  logic signed [smo_gus_pkg::PROD_W-1:0] s1_prod_high;
  logic signed [smo_gus_pkg::PROD_W-1:0] s1_prod_low;
  logic signed [smo_gus_pkg::VAL_W-1:0]  s1_f_old;
  logic [smo_gus_pkg::IDX_W-1:0]         s1_index;
  logic                                  s1_in_high;
  logic                                  s1_in_low;
  logic                                  s1_last;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_prod_high <= coef_high * $signed({1'b0, s0_kernel_high});
      s1_prod_low  <= coef_low * $signed({1'b0, s0_kernel_low});
      s1_f_old     <= s0_f_old;
      s1_index     <= s0_index;
      s1_in_high   <= s0_positive ? alpha_below : alpha_above;
      s1_in_low    <= s0_positive ? alpha_above : alpha_below;
      s1_last      <= s0_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: exact Q.32 sum, round half up, saturate to 32 bits. The rounding
  // constant sits in the empty low half of the shifted old gradient.
  // ---------------------------------------------------------------------------
  logic signed [smo_gus_pkg::ACC_W-1:0]      acc;
  logic signed [smo_gus_pkg::ACC_W-17:0]     rounded;
  logic signed [smo_gus_pkg::VAL_W-1:0]      f_sat;
  logic                                      fits;

  assign acc = smo_gus_pkg::ACC_W'($signed({s1_f_old, 16'h8000})) +
               smo_gus_pkg::ACC_W'(s1_prod_high) +
               smo_gus_pkg::ACC_W'(s1_prod_low);
  assign rounded = acc[smo_gus_pkg::ACC_W-1:16];
  assign fits = (rounded[smo_gus_pkg::ACC_W-17:smo_gus_pkg::VAL_W-1] == '0) ||
                (rounded[smo_gus_pkg::ACC_W-17:smo_gus_pkg::VAL_W-1] == '1);

  always_comb begin
    if (fits) begin
      f_sat = rounded[smo_gus_pkg::VAL_W-1:0];
    end else if (rounded[smo_gus_pkg::ACC_W-17]) begin
      f_sat = {1'b1, {(smo_gus_pkg::VAL_W-1){1'b0}}};
    end else begin
      f_sat = {1'b0, {(smo_gus_pkg::VAL_W-1){1'b1}}};
    end
  end

  logic signed [smo_gus_pkg::VAL_W-1:0] s2_f_new;
  logic [smo_gus_pkg::IDX_W-1:0]        s2_index;
  logic                                 s2_in_high;
  logic                                 s2_in_low;
  logic                                 s2_last;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_f_new   <= f_sat;
      s2_index   <= s1_index;
      s2_in_high <= s1_in_high;
      s2_in_low  <= s1_in_low;
      s2_last    <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: running minimum over the high set and maximum over the low set.
  // Strict compares keep the earliest point on ties. The tracking state moves
  // only when a point passes into the result register.
  // ---------------------------------------------------------------------------
  logic signed [smo_gus_pkg::VAL_W-1:0] best_high_value;
  logic [smo_gus_pkg::IDX_W-1:0]        best_high_index;
  logic                                 high_seen;
  logic signed [smo_gus_pkg::VAL_W-1:0] best_low_value;
  logic [smo_gus_pkg::IDX_W-1:0]        best_low_index;
  logic                                 low_seen;

  logic signed [smo_gus_pkg::VAL_W-1:0] best_high_value_next;
  logic [smo_gus_pkg::IDX_W-1:0]        best_high_index_next;
  logic                                 high_seen_next;
  logic signed [smo_gus_pkg::VAL_W-1:0] best_low_value_next;
  logic [smo_gus_pkg::IDX_W-1:0]        best_low_index_next;
  logic                                 low_seen_next;
  logic signed [smo_gus_pkg::VAL_W+1:0] high_bound;
  logic                                 gap_open;
  logic                                 retire;

  assign retire = s2_valid && out_load;

  always_comb begin
    best_high_value_next = best_high_value;
    best_high_index_next = best_high_index;
    high_seen_next       = high_seen;
    best_low_value_next  = best_low_value;
    best_low_index_next  = best_low_index;
    low_seen_next        = low_seen;
    if (s2_in_high && (!high_seen || (s2_f_new < best_high_value))) begin
      best_high_value_next = s2_f_new;
      best_high_index_next = s2_index;
      high_seen_next       = 1'b1;
    end
    if (s2_in_low && (!low_seen || (s2_f_new > best_low_value))) begin
      best_low_value_next = s2_f_new;
      best_low_index_next = s2_index;
      low_seen_next       = 1'b1;
    end
  end

  // Converged unless the low maximum lies above the high minimum by more than
  // twice the tolerance; an empty set always counts as converged.
  assign high_bound = (smo_gus_pkg::VAL_W + 2)'(best_high_value_next) +
                      (smo_gus_pkg::VAL_W + 2)'($signed({1'b0, tolerance, 1'b0}));
  assign gap_open   = (smo_gus_pkg::VAL_W + 2)'(best_low_value_next) > high_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_high_value <= '0;
      best_high_index <= '0;
      high_seen       <= 1'b0;
      best_low_value  <= '0;
      best_low_index  <= '0;
      low_seen        <= 1'b0;
    end else if (retire) begin
      if (s2_last) begin
        best_high_value <= '0;
        best_high_index <= '0;
        high_seen       <= 1'b0;
        best_low_value  <= '0;
        best_low_index  <= '0;
        low_seen        <= 1'b0;
      end else begin
        best_high_value <= best_high_value_next;
        best_high_index <= best_high_index_next;
        high_seen       <= high_seen_next;
        best_low_value  <= best_low_value_next;
        best_low_index  <= best_low_index_next;
        low_seen        <= low_seen_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. Summary fields are zero except on the last point of a pass.
  // ---------------------------------------------------------------------------
  logic                                 last_high;
  logic                                 last_low;

  assign last_high = s2_last && high_seen_next;
  assign last_low  = s2_last && low_seen_next;

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.f_new      <= s2_f_new;
      results.high_index <= last_high ? best_high_index_next : '0;
      results.high_value <= last_high ? best_high_value_next : '0;
      results.high_found <= last_high;
      results.low_index  <= last_low ? best_low_index_next : '0;
      results.low_value  <= last_low ? best_low_value_next : '0;
      results.low_found  <= last_low;
      results.converged  <= s2_last && !(high_seen_next && low_seen_next && gap_open);
      results.pass_end   <= s2_last;
    end
  end

  assign results.valid = out_valid;

endmodule

`default_nettype wire

>>> verif/smo_gus_tb_pkg.sv
`timescale 1ns / 100ps
// Transaction types and the gradient scoreboard for the SMO gradient update and selection bench.
// Depends on smo_gus_pkg for field widths and register codes.

package smo_gus_tb_pkg;
  import smo_gus_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]        point_index;
    logic signed [VAL_W-1:0] f_old;
    logic [KER_W-1:0]        kernel_high;
    logic [KER_W-1:0]        kernel_low;
    logic                    label_positive;
    logic [ALPHA_W-1:0]      alpha_value;
    logic                    last_point;
  } point_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] f_new;
    logic [IDX_W-1:0]        high_index;
    logic signed [VAL_W-1:0] high_value;
    logic                    high_found;
    logic [IDX_W-1:0]        low_index;
    logic signed [VAL_W-1:0] low_value;
    logic                    low_found;
    logic                    converged;
    logic                    pass_end;
  } result_t;

  localparam longint GRAD_MAX = 64'sd2147483647;
  localparam longint GRAD_MIN = -64'sd2147483648;

  class gradient_scoreboard;
    logic signed [VAL_W-1:0] coef_high;
    logic signed [VAL_W-1:0] coef_low;
    logic [COST_W-1:0]       cost;
    logic [EPS_W-1:0]        epsilon;
    logic [TOL_W-1:0]        tolerance;

    logic signed [VAL_W-1:0] min_high_grad;
    logic [IDX_W-1:0]        min_high_idx;
    bit                      high_seen;
    logic signed [VAL_W-1:0] max_low_grad;
    logic [IDX_W-1:0]        max_low_idx;
    bit                      low_seen;

    result_t predicted_updates[$];
    int errors;
    int points_seen;
    int passes_seen;
    int converged_passes;
    int saturated;

    function new();
      coef_high = '0;
      coef_low  = '0;
      cost      = COST_RESET;
      epsilon   = EPS_RESET;
      tolerance = TOL_RESET;
      clear_tracking();
    endfunction

    function void clear_tracking();
      min_high_grad = '0;
      min_high_idx  = '0;
      high_seen     = 1'b0;
      max_low_grad  = '0;
      max_low_idx   = '0;
      low_seen      = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [APB_DW-1:0] v);
      case (r)
        REG_COEF_HIGH: coef_high = v[VAL_W-1:0];
        REG_COEF_LOW:  coef_low  = v[VAL_W-1:0];
        REG_COST:      cost      = v[COST_W-1:0];
        REG_EPSILON:   epsilon   = v[EPS_W-1:0];
        REG_TOLERANCE: tolerance = v[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return predicted_updates.size();
    endfunction

    // Exact Q.32 sum, round half up to Q15.16, saturate, then update the running picks.
    function void note_point(point_t p);
      longint acc;
      longint fn;
      longint c_eps;
      longint alpha;
      logic signed [VAL_W-1:0] grad;
      bit in_high;
      bit in_low;
      result_t res;
      acc = longint'($signed(p.f_old)) * 65536
          + longint'(coef_high) * longint'(p.kernel_high)
          + longint'(coef_low) * longint'(p.kernel_low);
      fn = (acc + 32768) >>> 16;
      if (fn > GRAD_MAX) begin
        fn = GRAD_MAX;
        saturated++;
      end else if (fn < GRAD_MIN) begin
        fn = GRAD_MIN;
        saturated++;
      end
      grad = fn[VAL_W-1:0];

      c_eps = longint'(cost) - longint'(epsilon);
      alpha = longint'(p.alpha_value);
      if (p.label_positive) begin
        in_high = alpha < c_eps;
        in_low  = alpha > longint'(epsilon);
      end else begin
        in_high = alpha > longint'(epsilon);
        in_low  = alpha < c_eps;
      end

      if (in_high && (!high_seen || grad < min_high_grad)) begin
        min_high_grad = grad;
        min_high_idx  = p.point_index;
        high_seen     = 1'b1;
      end
      if (in_low && (!low_seen || grad > max_low_grad)) begin
        max_low_grad = grad;
        max_low_idx  = p.point_index;
        low_seen     = 1'b1;
      end

      res = '0;
      res.f_new = grad;
      if (p.last_point) begin
        res.converged = 1'b1;
        if (high_seen) begin
          res.high_index = min_high_idx;
          res.high_value = min_high_grad;
          res.high_found = 1'b1;
        end
        if (low_seen) begin
          res.low_index = max_low_idx;
          res.low_value = max_low_grad;
          res.low_found = 1'b1;
        end
        if (high_seen && low_seen)
          res.converged = !(longint'(max_low_grad) >
                            longint'(min_high_grad) + 2 * longint'(tolerance));
        res.pass_end = 1'b1;
        passes_seen++;
        if (res.converged) converged_passes++;
        clear_tracking();
      end
      predicted_updates.push_back(res);
      points_seen++;
    endfunction

    function void check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      end
    endfunction

    function void check_update(result_t r);
      result_t e;
      if (predicted_updates.size() == 0) begin
        errors++;
        $error("result transaction with no point outstanding, f_new %0h", r.f_new);
        return;
      end
      e = predicted_updates.pop_front();
      check_field("f_new",      e.f_new,      r.f_new);
      check_field("high_index", e.high_index, r.high_index);
      check_field("high_value", e.high_value, r.high_value);
      check_field("high_found", e.high_found, r.high_found);
      check_field("low_index",  e.low_index,  r.low_index);
      check_field("low_value",  e.low_value,  r.low_value);
      check_field("low_found",  e.low_found,  r.low_found);
      check_field("converged",  e.converged,  r.converged);
      check_field("pass_end",   e.pass_end,   r.pass_end);
    endfunction
  endclass

endpackage

>>> verif/tb_smo_gradient_update_select_top.sv
`timescale 1ns / 100ps
// Self-checking bench for smo_gradient_update_select_top: point and result streams plus APB.
// Depends on smo_gus_pkg, both channel interfaces, the RTL top and smo_gus_tb_pkg.

module tb_smo_gradient_update_select_top;
  import smo_gus_pkg::*;
  import smo_gus_tb_pkg::*;

  // The run is bounded by this fixed time; a correct run needs a small fraction of it.
  localparam int LIMIT_NS   = 2000000;
  // Long receiver hold-off, far longer than the four pipeline registers can absorb.
  localparam int LONG_HOLD  = 400;
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 225;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  smo_gus_point_if  pt_if ();
  smo_gus_result_if rs_if ();

  smo_gradient_update_select_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .points  (pt_if),
    .results (rs_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gradient_scoreboard sb = new();

  // Bench-side copy of the register file, used to aim alpha values at the set thresholds.
  logic [APB_DW-1:0] cfg_vals [5];
  int settings_written;
  int burst_left;
  // Hold-off requests come from the stimulus process; the receiver counts the ones it served.
  int hold_requests;
  int holds_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #LIMIT_NS;
    $display("DONE: errors detected");
    $finish;
  end

  // Monitor: every accepted point is predicted, every accepted result is checked, both
  // sampled at the rising edge on the values that the block itself sees.
  point_t  seen_point;
  result_t seen_result;
  always @(posedge clk) begin
    if (!rst) begin
      if (pt_if.valid && pt_if.ready) begin
        seen_point.point_index    = pt_if.point_index;
        seen_point.f_old          = pt_if.f_old;
        seen_point.kernel_high    = pt_if.kernel_high;
        seen_point.kernel_low     = pt_if.kernel_low;
        seen_point.label_positive = pt_if.label_positive;
        seen_point.alpha_value    = pt_if.alpha_value;
        seen_point.last_point     = pt_if.last_point;
        sb.note_point(seen_point);
      end
      if (rs_if.valid && rs_if.ready) begin
        seen_result.f_new      = rs_if.f_new;
        seen_result.high_index = rs_if.high_index;
        seen_result.high_value = rs_if.high_value;
        seen_result.high_found = rs_if.high_found;
        seen_result.low_index  = rs_if.low_index;
        seen_result.low_value  = rs_if.low_value;
        seen_result.low_found  = rs_if.low_found;
        seen_result.converged  = rs_if.converged;
        seen_result.pass_end   = rs_if.pass_end;
        sb.check_update(seen_result);
      end
    end
  end

  // Receiver: stretches of random length, each with its own stall pattern, so that ready
  // drops land on every pipeline phase. A pending hold-off request overrides the pattern and
  // keeps ready low long enough for the block to back up into the point channel.
  initial begin : rx_pattern
    rx_mode_t mode;
    int left;
    int period;
    int cyc;
    int hold_left;
    logic r;
    rs_if.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    period = 2;
    cyc = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(1, 64);
          period = $urandom_range(2, 5);
        end
        left--;
        case (mode)
          RX_OPEN:     r = 1'b1;
          RX_COIN:     r = $urandom_range(0, 1);
          RX_PERIODIC: r = (cyc % period) != 0;
          default:     r = ($urandom_range(0, 3) == 0);
        endcase
      end
      rs_if.ready <= r;
    end
  end

  // APB write: setup cycle, then access cycle; the register takes the value at the edge
  // where the access phase meets pready, and the scoreboard follows at that same edge.
  task automatic write_reg(cfg_reg_t r, logic [APB_DW-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(r));
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(r, v);
    cfg_vals[int'(r)] = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all(logic [APB_DW-1:0] ch, logic [APB_DW-1:0] cl,
                           logic [APB_DW-1:0] c, logic [APB_DW-1:0] e,
                           logic [APB_DW-1:0] t);
    write_reg(REG_COEF_HIGH, ch);
    write_reg(REG_COEF_LOW, cl);
    write_reg(REG_COST, c);
    write_reg(REG_EPSILON, e);
    write_reg(REG_TOLERANCE, t);
    settings_written++;
  endtask

  // Presents one point from a falling edge and holds it until the transaction completes.
  // Returns at the falling edge after acceptance so the next point can follow back to back.
  task automatic send_point(point_t p);
    pt_if.valid          <= 1'b1;
    pt_if.point_index    <= p.point_index;
    pt_if.f_old          <= p.f_old;
    pt_if.kernel_high    <= p.kernel_high;
    pt_if.kernel_low     <= p.kernel_low;
    pt_if.label_positive <= p.label_positive;
    pt_if.alpha_value    <= p.alpha_value;
    pt_if.last_point     <= p.last_point;
    @(posedge clk);
    while (!pt_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender side: points go out in bursts of random length with random gaps between them.
  task automatic offer(point_t p);
    int gap;
    send_point(p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(0, 24);
      if (gap > 0) begin
        pt_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Stops offering and waits for every predicted result, then lets the pipeline settle.
  task automatic wait_for_results();
    pt_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic point_t mk_point(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] f,
                                      logic [KER_W-1:0] kh, logic [KER_W-1:0] kl,
                                      logic pos, logic [ALPHA_W-1:0] a, logic last);
    point_t p;
    p.point_index    = idx;
    p.f_old          = f;
    p.kernel_high    = kh;
    p.kernel_low     = kl;
    p.label_positive = pos;
    p.alpha_value    = a;
    p.last_point     = last;
    return p;
  endfunction

  // Random point. Gradients cluster on a few values so ties are common, kernels are often
  // zero so the gradient passes straight through, and alpha is aimed at the set boundaries.
  function automatic point_t gen_point(logic [IDX_W-1:0] idx, logic last);
    point_t p;
    longint c_eps;
    longint eps;
    longint a;
    int s;
    eps   = longint'(cfg_vals[REG_EPSILON][EPS_W-1:0]);
    c_eps = longint'(cfg_vals[REG_COST][COST_W-1:0]) - eps;
    p.point_index    = idx;
    p.last_point     = last;
    p.label_positive = $urandom_range(0, 1);
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        s = int'($urandom_range(0, 6)) - 3;
        p.f_old = s * 65536;
      end
      3:       p.f_old = $urandom();
      4:       p.f_old = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: p.f_old = int'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      p.kernel_high = '0;
      p.kernel_low  = '0;
    end else begin
      p.kernel_high = ($urandom_range(0, 7) == 0) ? KER_W'($urandom_range(0, 17'h1FFFF))
                                                  : KER_W'($urandom_range(0, 65536));
      p.kernel_low  = ($urandom_range(0, 7) == 0) ? KER_W'($urandom_range(0, 17'h1FFFF))
                                                  : KER_W'($urandom_range(0, 65536));
    end
    case ($urandom_range(0, 9))
      0:       a = 0;
      1:       a = eps;
      2:       a = eps + 1;
      3:       a = eps - 1;
      4:       a = c_eps;
      5:       a = c_eps - 1;
      6:       a = c_eps + 1;
      7:       a = longint'($urandom()) & 64'h7FFF_FFFF;
      default: a = longint'($urandom_range(0, 32'(cfg_vals[REG_COST][COST_W-1:0])));
    endcase
    if (a < 0) a = 0;
    if (a > longint'(ALPHA_MAX)) a = longint'(ALPHA_MAX);
    p.alpha_value = a[ALPHA_W-1:0];
    return p;
  endfunction

  // Register values for a random phase: mostly moderate, with the extremes mixed in.
  function automatic logic [APB_DW-1:0] random_setting(cfg_reg_t r);
    logic [APB_DW-1:0] v;
    case (r)
      REG_COEF_HIGH, REG_COEF_LOW: begin
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h8000_0000;
          3:       v = $urandom();
          default: v = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
      end
      REG_COST: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0001_0000;
          3:       v = $urandom() & 32'h7FFF_FFFF;
          default: v = $urandom_range(0, 32'h0010_0000);
        endcase
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = 32'h0000_FFFF;
          2:       v = $urandom_range(0, 16'hFFFF);
          default: v = $urandom_range(0, 4096);
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic run_pass(int len);
    logic [IDX_W-1:0] base;
    base = $urandom_range(0, 16'hFFFF);
    for (int k = 0; k < len; k++)
      offer(gen_point(IDX_W'(base + k), k == len - 1));
  endtask

  initial begin : stimulus
    int items;
    int len;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    pt_if.valid          = 1'b0;
    pt_if.point_index    = '0;
    pt_if.f_old          = '0;
    pt_if.kernel_high    = '0;
    pt_if.kernel_low     = '0;
    pt_if.label_positive = 1'b0;
    pt_if.alpha_value    = '0;
    pt_if.last_point     = 1'b0;
    cfg_vals[REG_COEF_HIGH] = '0;
    cfg_vals[REG_COEF_LOW]  = '0;
    cfg_vals[REG_COST]      = 32'(COST_RESET);
    cfg_vals[REG_EPSILON]   = 32'(EPS_RESET);
    cfg_vals[REG_TOLERANCE] = 32'(TOL_RESET);
    settings_written = 1;
    burst_left       = 0;
    hold_requests    = 0;
    holds_done       = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register defaults: zero coefficients pass the gradient through. Extreme gradients and
    // indices, a tie in the low set won by the earlier point, then a one-point pass whose
    // high set stays empty so it counts as converged.
    offer(mk_point(16'h0000, 32'h7FFF_FFFF, '0, '0, 1'b1, '0, 1'b0));
    offer(mk_point(16'hFFFF, 32'h8000_0000, '0, '0, 1'b0, ALPHA_MAX, 1'b0));
    offer(mk_point(16'd5, 32'sd100, 17'h1FFFF, 17'h1FFFF, 1'b1, 31'd2, 1'b0));
    offer(mk_point(16'd6, 32'sd100, '0, '0, 1'b1, 31'd2, 1'b1));
    offer(mk_point(16'd7, -32'sd5, '0, '0, 1'b0, 31'd1, 1'b1));
    wait_for_results();

    // Largest coefficients with kernels above one saturate upward; a three-way tie at zero
    // in the low set, and an alpha exactly at cost minus epsilon, which is outside.
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    offer(mk_point(16'd1, 32'h7FFF_FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1, '0, 1'b0));
    offer(mk_point(16'd2, '0, '0, '0, 1'b0, 31'h0001_0000, 1'b0));
    offer(mk_point(16'd3, '0, '0, '0, 1'b1, ALPHA_MAX, 1'b0));
    offer(mk_point(16'd4, '0, '0, '0, 1'b1, 31'h7FFF_0000, 1'b1));
    wait_for_results();

    // Most negative coefficients saturate downward; zero cost and epsilon leave a point with
    // zero alpha in neither set, then a pass that does not converge with zero tolerance.
    write_all(32'h8000_0000, 32'h8000_0000, '0, '0, '0);
    offer(mk_point(16'd8, 32'h8000_0000, 17'h1FFFF, 17'h1FFFF, 1'b0, '0, 1'b1));
    offer(mk_point(16'd9, 32'h0001_0000, '0, '0, 1'b1, 31'd5, 1'b0));
    offer(mk_point(16'd10, '0, '0, '0, 1'b0, 31'd5, 1'b1));
    wait_for_results();

    // Cost below epsilon: nothing lies below cost minus epsilon. Unit coefficients with half
    // kernels land exactly on the rounding boundary on both sides of zero.
    write_all(32'h0000_0001, 32'hFFFF_FFFF, 32'd10, 32'h0000_FFFF, 32'h0000_8000);
    offer(mk_point(16'd11, '0, 17'h08000, '0, 1'b1, '0, 1'b0));
    offer(mk_point(16'd12, '0, '0, 17'h08000, 1'b0, '0, 1'b0));
    offer(mk_point(16'd13, '0, '0, 17'h08001, 1'b1, ALPHA_MAX, 1'b0));
    offer(mk_point(16'd14, 32'sd3, '0, '0, 1'b0, 31'h0001_0000, 1'b1));
    wait_for_results();

    // Random phases: each starts from an idle block with a fresh register setting and runs
    // whole passes, mostly short ones. In one phase the receiver also holds off for a long
    // stretch while points keep coming, which backs the pipeline up into the point channel.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_results();
      for (int i = 0; i < 5; i++)
        write_reg(cfg_reg_t'(i), random_setting(cfg_reg_t'(i)));
      settings_written++;
      if (ph == 2) hold_requests++;
      items = 0;
      while (items < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        run_pass(len);
        items += len;
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $error("%0d predicted results never arrived", sb.pending());
    end

    $display("Run covered %0d points in %0d passes under %0d register settings.",
             sb.points_seen, sb.passes_seen, settings_written);
    $display("%0d passes converged and %0d gradients saturated.",
             sb.converged_passes, sb.saturated);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> smo_gradient_update_select_top.f
src/smo_gus_pkg.sv
src/smo_gus_point_if.sv
src/smo_gus_result_if.sv
src/smo_gradient_update_select_top.sv
verif/smo_gus_tb_pkg.sv
verif/tb_smo_gradient_update_select_top.sv
